[design/ttfe_pkg.sv]
// Package for the battery time-to-full / time-to-empty estimator.
// Holds field widths, register indexes, arithmetic constants and the microcode ROM.
// No dependencies; every other design file imports it.
package ttfe_pkg;

	localparam int CAP_BITS_DEF = 20;
	localparam int WORD_W       = 16;
	localparam int SV1_W        = WORD_W + 1;
	localparam int VSTATE_W     = 2;
	localparam int DIR_W        = 2;
	localparam int CFG_IDX_W    = 4;

	// Divider geometry: divisor covers current*10, rated dividend is power*10000.
	localparam int DIV_VW       = 20;
	localparam int RATED_W      = 30;
	localparam int SCALE_W      = 14;

	localparam logic [SCALE_W-1:0] RATED_SCALE = 14'd10000;
	localparam logic [2:0]         CAP_MUL     = 3'd6;
	localparam logic [3:0]         TIME_DIV    = 4'd10;
	localparam logic [WORD_W-1:0]  TIME_MAX    = 16'hFFFF;
	localparam logic [WORD_W-1:0]  RATED_RESET = 16'd100;

	localparam logic signed [WORD_W-1:0] NEG_ONE = -16'sd1;
	localparam logic signed [WORD_W-1:0] POS_ONE = 16'sd1;

	localparam logic [CFG_IDX_W-1:0] REG_CHG_RATED_POWER = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DHG_RATED_POWER = 4'd1;

	localparam logic [VSTATE_W-1:0] VSTATE_OVER  = 2'd1;
	localparam logic [VSTATE_W-1:0] VSTATE_UNDER = 2'd2;

	localparam logic [DIR_W-1:0] DIR_CHARGE    = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DISCHARGE = 2'd2;

	// Microcode operations.
	localparam logic [2:0] OP_IDLE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_WAIT  = 3'd2;
	localparam logic [2:0] OP_UPD   = 3'd3;
	localparam logic [2:0] OP_OUT   = 3'd4;
	localparam logic [2:0] OP_JMP   = 3'd5;

	// Operand selects: rated charge, rated discharge, time to full, time to empty.
	localparam logic [1:0] SEL_RC = 2'd0;
	localparam logic [1:0] SEL_RD = 2'd1;
	localparam logic [1:0] SEL_TF = 2'd2;
	localparam logic [1:0] SEL_TE = 2'd3;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_OUT  = 4'd11;

	typedef struct packed {
		logic [2:0]        op;
		logic [1:0]        sel;
		logic [STEP_W-1:0] tgt;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		unique case (step)
			4'd0:    cw = '{op: OP_IDLE,  sel: SEL_RC, tgt: STEP_OUT};
			4'd1:    cw = '{op: OP_START, sel: SEL_RC, tgt: STEP_IDLE};
			4'd2:    cw = '{op: OP_WAIT,  sel: SEL_RC, tgt: STEP_IDLE};
			4'd3:    cw = '{op: OP_START, sel: SEL_RD, tgt: STEP_IDLE};
			4'd4:    cw = '{op: OP_WAIT,  sel: SEL_RD, tgt: STEP_IDLE};
			4'd5:    cw = '{op: OP_START, sel: SEL_TF, tgt: STEP_IDLE};
			4'd6:    cw = '{op: OP_WAIT,  sel: SEL_TF, tgt: STEP_IDLE};
			4'd7:    cw = '{op: OP_UPD,   sel: SEL_TF, tgt: STEP_IDLE};
			4'd8:    cw = '{op: OP_START, sel: SEL_TE, tgt: STEP_IDLE};
			4'd9:    cw = '{op: OP_WAIT,  sel: SEL_TE, tgt: STEP_IDLE};
			4'd10:   cw = '{op: OP_UPD,   sel: SEL_TE, tgt: STEP_IDLE};
			4'd11:   cw = '{op: OP_OUT,   sel: SEL_RC, tgt: STEP_IDLE};
			default: cw = '{op: OP_JMP,   sel: SEL_RC, tgt: STEP_IDLE};
		endcase
		return cw;
	endfunction

endpackage

[design/ttfe_if.sv]
// Channel interfaces of the estimator: snapshot input, estimate output, register writes.
// Depends on ttfe_pkg for widths.
interface ttfe_snap_if #(parameter int CAP_BITS = ttfe_pkg::CAP_BITS_DEF);
	import ttfe_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       in_init;
	logic [CAP_BITS-1:0]        now_cap;
	logic [CAP_BITS-1:0]        total_cap;
	logic [WORD_W-1:0]          sum_volt;
	logic signed [WORD_W-1:0]   out_power;
	logic                       volt_high_limit;
	logic                       volt_low_limit;
	logic [VSTATE_W-1:0]        batt_volt_state;
	logic [DIR_W-1:0]           curr_dir;
	logic signed [WORD_W-1:0]   avg_current;
	logic [WORD_W-1:0]          chg_limit_curr;
	logic [WORD_W-1:0]          dhg_limit_curr;

	modport source (output valid, in_init, now_cap, total_cap, sum_volt, out_power,
		volt_high_limit, volt_low_limit, batt_volt_state, curr_dir, avg_current,
		chg_limit_curr, dhg_limit_curr, input ready);
	modport sink (input valid, in_init, now_cap, total_cap, sum_volt, out_power,
		volt_high_limit, volt_low_limit, batt_volt_state, curr_dir, avg_current,
		chg_limit_curr, dhg_limit_curr, output ready);
endinterface

interface ttfe_est_if;
	import ttfe_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] time_to_full;
	logic [WORD_W-1:0] time_to_empty;

	modport source (output valid, time_to_full, time_to_empty, input ready);
	modport sink (input valid, time_to_full, time_to_empty, output ready);
endinterface

interface ttfe_cfg_if;
	import ttfe_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/battery_time_to_full_empty_estimator.sv]
// Top level of the battery time-to-full / time-to-empty estimator.
// Depends on ttfe_pkg, the channel interfaces in ttfe_if.sv and the divider ttfe_div.
//
// A snapshot transfer on the snapshot channel starts one estimate; each snapshot gives
// exactly one transfer on the estimate channel with the smoothed time to full and time
// to empty in minutes. Rated charge and discharge power are written on the cfg channel,
// which is always ready, by register index 0 and 1; the user must write them only while
// no snapshot is in flight, as the block itself does not enforce it.
// A microcoded sequencer steps through a twelve-word program. It runs four divisions on
// one shared divider that retires two quotient bits per cycle; the divider width is
// DW = max(30, CAP_BITS + 3) rounded up to even. The next snapshot is taken only after
// the last one's estimate has gone into the output register. A snapshot marked as
// init skips the divisions and goes straight to the output step with the held
// estimates.
// The estimate sits in an output register: while the receiver stalls, the next snapshot
// is already worked on, and only its final step waits for the register to drain.
// Reset clears both estimates to zero, sets both rated powers to 100 and empties the
// output register.
module battery_time_to_full_empty_estimator #(
	parameter int CAP_BITS = ttfe_pkg::CAP_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	ttfe_snap_if.sink     snapshot,
	ttfe_est_if.source    estimate,
	ttfe_cfg_if.sink      cfg
);
	import ttfe_pkg::*;

	localparam int CAP6_W = CAP_BITS + 3;
	localparam int DW_RAW = (CAP6_W > RATED_W) ? CAP6_W : RATED_W;
	localparam int DW     = DW_RAW + (DW_RAW % 2);

	logic [STEP_W-1:0]   step_q, step_n;
	ctrl_word_t          cw;

	logic [WORD_W-1:0]   chg_pw_q, dhg_pw_q;
	logic [WORD_W-1:0]   full_q, empty_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_full_q, out_empty_q;

	logic [CAP_BITS-1:0] chg_cap_q, dhg_cap_q;
	logic [SV1_W-1:0]    sv1_q;
	logic                meas_chg_q, meas_dhg_q;
	logic [WORD_W-1:0]   chg_curr_q, dhg_curr_q;
	logic [WORD_W-1:0]   chg_lim_q, dhg_lim_q;
	logic [DW-1:0]       raw_q;

	logic                snap_xfer, out_free;
	logic                over_v, under_v, meas_chg, meas_dhg;
	logic [CAP_BITS-1:0] chg_cap;

	logic                div_start, div_busy;
	logic [DW-1:0]       div_dividend, div_quotient;
	logic [DIV_VW-1:0]   div_divisor;
	logic [RATED_W-1:0]  rated_prod;
	logic [CAP6_W-1:0]   cap_prod;
	logic [DIV_VW-1:0]   curr_prod;

	logic [WORD_W-1:0]   upd_old, upd_curr, upd_lim, upd_new;
	logic [DW:0]         upd_sum;
	logic [DW-1:0]       upd_mean;

	assign cw        = ucode_rom(step_q);
	assign snapshot.ready = (cw.op == OP_IDLE);
	assign snap_xfer = snapshot.valid && snapshot.ready;
	assign out_free  = !out_valid_q || estimate.ready;
	assign cfg.ready = 1'b1;

	// Snapshot decoding.
	always_comb begin
		over_v  = snapshot.volt_high_limit || (snapshot.batt_volt_state == VSTATE_OVER);
		under_v = snapshot.volt_low_limit || (snapshot.batt_volt_state == VSTATE_UNDER);
		chg_cap = (snapshot.total_cap >= snapshot.now_cap) ?
			snapshot.total_cap - snapshot.now_cap : '0;
		meas_chg = (snapshot.curr_dir == DIR_CHARGE) && (snapshot.out_power < NEG_ONE) &&
			(snapshot.avg_current < NEG_ONE);
		meas_dhg = (snapshot.curr_dir == DIR_DISCHARGE) && (snapshot.out_power > POS_ONE) &&
			(snapshot.avg_current > POS_ONE);
	end

	// Sequencing.
	always_comb begin
		step_n = step_q;
		unique case (cw.op)
			OP_IDLE: begin
				if (snap_xfer) begin
					step_n = snapshot.in_init ? cw.tgt : step_q + STEP_W'(1);
				end
			end
			OP_START, OP_UPD: step_n = step_q + STEP_W'(1);
			OP_WAIT: begin
				if (!div_busy) begin
					step_n = step_q + STEP_W'(1);
				end
			end
			OP_OUT: begin
				if (out_free) begin
					step_n = cw.tgt;
				end
			end
			OP_JMP:  step_n = cw.tgt;
			default: step_n = STEP_IDLE;
		endcase
	end

	// Divider operand selection.
	always_comb begin
		rated_prod = RATED_W'(chg_pw_q) * RATED_W'(RATED_SCALE);
		cap_prod   = CAP6_W'(chg_cap_q) * CAP6_W'(CAP_MUL);
		curr_prod  = DIV_VW'(chg_curr_q) * DIV_VW'(TIME_DIV);
		unique case (cw.sel)
			SEL_RC: begin
				rated_prod = RATED_W'(chg_pw_q) * RATED_W'(RATED_SCALE);
			end
			SEL_RD: begin
				rated_prod = RATED_W'(dhg_pw_q) * RATED_W'(RATED_SCALE);
			end
			SEL_TF: begin
				cap_prod  = CAP6_W'(chg_cap_q) * CAP6_W'(CAP_MUL);
				curr_prod = DIV_VW'(chg_curr_q) * DIV_VW'(TIME_DIV);
			end
			SEL_TE: begin
				cap_prod  = CAP6_W'(dhg_cap_q) * CAP6_W'(CAP_MUL);
				curr_prod = DIV_VW'(dhg_curr_q) * DIV_VW'(TIME_DIV);
			end
		endcase
		if (cw.sel == SEL_RC || cw.sel == SEL_RD) begin
			div_dividend = DW'(rated_prod);
			div_divisor  = DIV_VW'(sv1_q);
		end else begin
			div_dividend = DW'(cap_prod);
			div_divisor  = curr_prod;
		end
		div_start = (cw.op == OP_START);
	end

	ttfe_div #(
		.DW (DW),
		.VW (DIV_VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quotient)
	);

	// Estimate update: TIME_MAX at zero current, one in the last minute, else mean with old.
	always_comb begin
		if (cw.sel == SEL_TF) begin
			upd_old  = full_q;
			upd_curr = chg_curr_q;
			upd_lim  = chg_lim_q;
		end else begin
			upd_old  = empty_q;
			upd_curr = dhg_curr_q;
			upd_lim  = dhg_lim_q;
		end
		upd_sum  = (DW + 1)'(upd_old) + (DW + 1)'(raw_q);
		upd_mean = upd_sum[DW:1];
		priority if (upd_curr == '0) begin
			upd_new = TIME_MAX;
		end else if (raw_q <= DW'(1) && upd_lim != '0) begin
			upd_new = WORD_W'(1);
		end else if (upd_mean > DW'(TIME_MAX)) begin
			upd_new = TIME_MAX;
		end else begin
			upd_new = upd_mean[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			chg_pw_q    <= RATED_RESET;
			dhg_pw_q    <= RATED_RESET;
			full_q      <= '0;
			empty_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_n;
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_CHG_RATED_POWER) begin
					chg_pw_q <= cfg.data;
				end else if (cfg.index == REG_DHG_RATED_POWER) begin
					dhg_pw_q <= cfg.data;
				end
			end
			if (cw.op == OP_UPD) begin
				if (cw.sel == SEL_TF) begin
					full_q <= upd_new;
				end else begin
					empty_q <= upd_new;
				end
			end
			if (cw.op == OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (estimate.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_xfer) begin
			chg_cap_q  <= over_v ? '0 : chg_cap;
			dhg_cap_q  <= under_v ? '0 : snapshot.now_cap;
			sv1_q      <= SV1_W'(snapshot.sum_volt) + SV1_W'(1);
			meas_chg_q <= meas_chg;
			meas_dhg_q <= meas_dhg;
			chg_curr_q <= WORD_W'(-snapshot.avg_current);
			dhg_curr_q <= snapshot.avg_current;
			chg_lim_q  <= snapshot.chg_limit_curr;
			dhg_lim_q  <= snapshot.dhg_limit_curr;
		end
		if (cw.op == OP_WAIT && !div_busy) begin
			unique case (cw.sel)
				SEL_RC: begin
					if (!meas_chg_q) begin
						chg_curr_q <= div_quotient[WORD_W-1:0];
					end
				end
				SEL_RD: begin
					if (!meas_dhg_q) begin
						dhg_curr_q <= div_quotient[WORD_W-1:0];
					end
				end
				SEL_TF, SEL_TE: raw_q <= div_quotient;
			endcase
		end
		if (cw.op == OP_OUT && out_free) begin
			out_full_q  <= full_q;
			out_empty_q <= empty_q;
		end
	end

	assign estimate.valid         = out_valid_q;
	assign estimate.time_to_full  = out_full_q;
	assign estimate.time_to_empty = out_empty_q;

endmodule

[design/ttfe_div.sv]
// Unsigned restoring divider, two quotient bits per cycle, shared by all estimator divisions.
// Depends on ttfe_pkg only through the import convention; widths come from parameters.
module ttfe_div #(
	parameter int DW = 30,
	parameter int VW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);
	import ttfe_pkg::*;

	localparam int ITER = DW / 2;
	localparam int CW   = $clog2(ITER + 1);

	logic [DW-1:0] acc_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [VW:0]   t1, t2;
	logic          ge1, ge2;
	logic [VW-1:0] r1, r2;

	always_comb begin
		t1  = {rem_q, acc_q[DW-1]};
		ge1 = t1 >= {1'b0, dvs_q};
		r1  = ge1 ? VW'(t1 - {1'b0, dvs_q}) : t1[VW-1:0];
		t2  = {r1, acc_q[DW-2]};
		ge2 = t2 >= {1'b0, dvs_q};
		r2  = ge2 ? VW'(t2 - {1'b0, dvs_q}) : t2[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ITER);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DW-3:0], ge1, ge2};
			rem_q <= r2;
		end
	end

	assign busy     = busy_q;
	assign quotient = acc_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench for battery_time_to_full_empty_estimator: directed and random pack snapshots,
// a built-in predictor of the smoothed time estimates, and a field-by-field check.
// Depends on ttfe_pkg, the channel interfaces in ttfe_if.sv and the estimator RTL.
module tb;
	import ttfe_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_BLOCKS = 6;
	localparam int BLOCK_ITEMS = 320;
	localparam int SETTLE_CYCLES = 100;

	localparam logic [DIR_W-1:0]    DIR_SPARE    = 2'd3;
	localparam logic [VSTATE_W-1:0] VSTATE_SPARE = 2'd3;

	typedef struct {
		logic                       in_init;
		logic [CAP_BITS_DEF-1:0]    now_cap;
		logic [CAP_BITS_DEF-1:0]    total_cap;
		logic [WORD_W-1:0]          sum_volt;
		logic signed [WORD_W-1:0]   out_power;
		logic                       volt_high_limit;
		logic                       volt_low_limit;
		logic [VSTATE_W-1:0]        batt_volt_state;
		logic [DIR_W-1:0]           curr_dir;
		logic signed [WORD_W-1:0]   avg_current;
		logic [WORD_W-1:0]          chg_limit_curr;
		logic [WORD_W-1:0]          dhg_limit_curr;
	} snapshot_t;

	typedef struct {
		logic [WORD_W-1:0] time_to_full;
		logic [WORD_W-1:0] time_to_empty;
	} times_t;

	logic clk;
	logic arst_n;

	ttfe_snap_if snap_ch ();
	ttfe_est_if  est_ch ();
	ttfe_cfg_if  cfg_ch ();

	battery_time_to_full_empty_estimator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.snapshot (snap_ch),
		.estimate (est_ch),
		.cfg      (cfg_ch)
	);

	snapshot_t   pending_snaps[$];
	times_t      expected_times[$];
	snapshot_t   driven_snap;
	logic [WORD_W-1:0] chg_power = RATED_RESET;
	logic [WORD_W-1:0] dhg_power = RATED_RESET;
	logic [WORD_W-1:0] full_est = '0;
	logic [WORD_W-1:0] empty_est = '0;
	int          outstanding = 0;
	int          mismatches = 0;
	int          cycles = 0;
	int          tx_idle_pct = 25;
	int          rx_idle_pct = 61;

	function automatic logic [WORD_W-1:0] smooth_time(input logic [WORD_W-1:0] old,
		input logic [63:0] cap, input logic [63:0] curr, input logic [WORD_W-1:0] limit);
		logic [63:0] raw;
		logic [63:0] mean;
		if (curr == 0)
			return TIME_MAX;
		raw = cap * 64'(CAP_MUL) / curr / 64'(TIME_DIV);
		if (raw <= 1 && limit != 0)
			return 16'd1;
		mean = (64'(old) + raw) / 2;
		return (mean > 64'(TIME_MAX)) ? TIME_MAX : mean[WORD_W-1:0];
	endfunction

	function automatic times_t estimate_times(input snapshot_t s);
		logic [63:0] chg_cap;
		logic [63:0] dhg_cap;
		logic [63:0] divisor;
		logic [63:0] chg_curr;
		logic [63:0] dhg_curr;
		times_t t;
		if (!s.in_init) begin
			divisor = 64'(s.sum_volt) + 1;
			dhg_cap = 64'(s.now_cap);
			chg_cap = (s.total_cap >= s.now_cap) ? 64'(s.total_cap - s.now_cap) : 64'd0;
			if (s.volt_high_limit || s.batt_volt_state == VSTATE_OVER)
				chg_cap = 0;
			if (s.volt_low_limit || s.batt_volt_state == VSTATE_UNDER)
				dhg_cap = 0;
			chg_curr = (64'(chg_power) * 64'(RATED_SCALE) / divisor) & 64'hFFFF;
			dhg_curr = (64'(dhg_power) * 64'(RATED_SCALE) / divisor) & 64'hFFFF;
			if (s.curr_dir == DIR_CHARGE) begin
				if (s.out_power < NEG_ONE && s.avg_current < NEG_ONE)
					chg_curr = 64'(-int'(s.avg_current));
			end else if (s.curr_dir == DIR_DISCHARGE) begin
				if (s.out_power > POS_ONE && s.avg_current > POS_ONE)
					dhg_curr = 64'(int'(s.avg_current));
			end
			full_est = smooth_time(full_est, chg_cap, chg_curr, s.chg_limit_curr);
			empty_est = smooth_time(empty_est, dhg_cap, dhg_curr, s.dhg_limit_curr);
		end
		t.time_to_full = full_est;
		t.time_to_empty = empty_est;
		return t;
	endfunction

	function automatic snapshot_t nominal_snap();
		snapshot_t s;
		s.in_init = 1'b0;
		s.now_cap = 20'd5000;
		s.total_cap = 20'd20000;
		s.sum_volt = 16'd3300;
		s.out_power = 16'sd0;
		s.volt_high_limit = 1'b0;
		s.volt_low_limit = 1'b0;
		s.batt_volt_state = '0;
		s.curr_dir = '0;
		s.avg_current = 16'sd0;
		s.chg_limit_curr = 16'd100;
		s.dhg_limit_curr = 16'd100;
		return s;
	endfunction

	function automatic snapshot_t random_snap();
		snapshot_t s;
		int kind;
		s.in_init = ($urandom_range(19) == 0);
		kind = $urandom_range(9);
		if (kind == 0) begin
			s.total_cap = CAP_BITS_DEF'($urandom);
			s.now_cap = CAP_BITS_DEF'($urandom);
		end else if (kind == 1) begin
			s.total_cap = CAP_BITS_DEF'($urandom_range(3));
			s.now_cap = CAP_BITS_DEF'($urandom_range(3));
		end else begin
			s.total_cap = CAP_BITS_DEF'($urandom);
			s.now_cap = CAP_BITS_DEF'($urandom_range(s.total_cap));
		end
		s.sum_volt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(60000, 2000));
		kind = $urandom_range(9);
		if (kind < 4)
			s.curr_dir = DIR_CHARGE;
		else if (kind < 8)
			s.curr_dir = DIR_DISCHARGE;
		else
			s.curr_dir = DIR_W'($urandom_range(3));
		kind = $urandom_range(9);
		if (kind < 8 && s.curr_dir == DIR_CHARGE) begin
			s.out_power = 16'(-$urandom_range(32768, 2));
			s.avg_current = ($urandom_range(3) == 0) ? 16'(-$urandom_range(32768, 2))
				: 16'(-$urandom_range(200, 2));
		end else if (kind < 8 && s.curr_dir == DIR_DISCHARGE) begin
			s.out_power = 16'($urandom_range(32767, 2));
			s.avg_current = ($urandom_range(3) == 0) ? 16'($urandom_range(32767, 2))
				: 16'($urandom_range(200, 2));
		end else begin
			s.out_power = ($urandom_range(1) == 0) ? 16'($urandom)
				: 16'($urandom_range(3) - 2);
			s.avg_current = ($urandom_range(1) == 0) ? 16'($urandom)
				: 16'($urandom_range(3) - 2);
		end
		s.volt_high_limit = ($urandom_range(9) == 0);
		s.volt_low_limit = ($urandom_range(9) == 0);
		s.batt_volt_state = ($urandom_range(4) == 0) ? VSTATE_W'($urandom_range(3)) : '0;
		s.chg_limit_curr = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
		s.dhg_limit_curr = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
		return s;
	endfunction

	task automatic queue_snap(input snapshot_t s);
		pending_snaps.push_back(s);
		outstanding++;
	endtask

	task automatic wait_drained();
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_CHG_RATED_POWER)
			chg_power = val;
		else if (idx == REG_DHG_RATED_POWER)
			dhg_power = val;
	endtask

	task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s mismatch: expected %0d, got %0d", field, want, got);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_ch.valid <= 1'b0;
		end else begin
			if (snap_ch.valid && snap_ch.ready)
				expected_times.push_back(estimate_times(driven_snap));
			if (!snap_ch.valid || snap_ch.ready) begin
				if (pending_snaps.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					driven_snap = pending_snaps.pop_front();
					snap_ch.valid <= 1'b1;
					snap_ch.in_init <= driven_snap.in_init;
					snap_ch.now_cap <= driven_snap.now_cap;
					snap_ch.total_cap <= driven_snap.total_cap;
					snap_ch.sum_volt <= driven_snap.sum_volt;
					snap_ch.out_power <= driven_snap.out_power;
					snap_ch.volt_high_limit <= driven_snap.volt_high_limit;
					snap_ch.volt_low_limit <= driven_snap.volt_low_limit;
					snap_ch.batt_volt_state <= driven_snap.batt_volt_state;
					snap_ch.curr_dir <= driven_snap.curr_dir;
					snap_ch.avg_current <= driven_snap.avg_current;
					snap_ch.chg_limit_curr <= driven_snap.chg_limit_curr;
					snap_ch.dhg_limit_curr <= driven_snap.dhg_limit_curr;
				end else begin
					snap_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		times_t want;
		if (!arst_n) begin
			est_ch.ready <= 1'b0;
		end else begin
			est_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			if (est_ch.valid && est_ch.ready) begin
				if (expected_times.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("estimate with no snapshot outstanding: full %0d, empty %0d",
							est_ch.time_to_full, est_ch.time_to_empty);
				end else begin
					want = expected_times.pop_front();
					if (est_ch.time_to_full !== want.time_to_full)
						report_mismatch("time_to_full", want.time_to_full, est_ch.time_to_full);
					if (est_ch.time_to_empty !== want.time_to_empty)
						report_mismatch("time_to_empty", want.time_to_empty, est_ch.time_to_empty);
					outstanding--;
				end
			end
		end
	end

	initial begin
		snapshot_t s;
		logic [WORD_W-1:0] chg_plan[RANDOM_BLOCKS];
		logic [WORD_W-1:0] dhg_plan[RANDOM_BLOCKS];

		arst_n = 1'b0;
		snap_ch.valid = 1'b0;
		driven_snap = nominal_snap();
		s = driven_snap;
		snap_ch.in_init = s.in_init;
		snap_ch.now_cap = s.now_cap;
		snap_ch.total_cap = s.total_cap;
		snap_ch.sum_volt = s.sum_volt;
		snap_ch.out_power = s.out_power;
		snap_ch.volt_high_limit = s.volt_high_limit;
		snap_ch.volt_low_limit = s.volt_low_limit;
		snap_ch.batt_volt_state = s.batt_volt_state;
		snap_ch.curr_dir = s.curr_dir;
		snap_ch.avg_current = s.avg_current;
		snap_ch.chg_limit_curr = s.chg_limit_curr;
		snap_ch.dhg_limit_curr = s.dhg_limit_curr;
		est_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_CHG_RATED_POWER;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed snapshots run with the rated powers left at their reset values.
		queue_snap(nominal_snap());
		s = nominal_snap();
		s.curr_dir = DIR_CHARGE;
		s.out_power = -16'sd500;
		s.avg_current = -16'sd300;
		queue_snap(s);
		s.out_power = NEG_ONE;
		queue_snap(s);
		s.out_power = -16'sd500;
		s.avg_current = NEG_ONE;
		queue_snap(s);
		s.out_power = 16'sh8000;
		s.avg_current = 16'sh8000;
		s.total_cap = '1;
		s.now_cap = '0;
		queue_snap(s);
		s = nominal_snap();
		s.curr_dir = DIR_DISCHARGE;
		s.out_power = 16'sd500;
		s.avg_current = 16'sd300;
		queue_snap(s);
		s.out_power = POS_ONE;
		queue_snap(s);
		s.out_power = 16'sh7FFF;
		s.avg_current = 16'sh7FFF;
		s.now_cap = '1;
		queue_snap(s);
		s = nominal_snap();
		s.curr_dir = DIR_SPARE;
		s.out_power = -16'sd500;
		s.avg_current = -16'sd300;
		queue_snap(s);
		s = nominal_snap();
		s.volt_high_limit = 1'b1;
		queue_snap(s);
		s = nominal_snap();
		s.batt_volt_state = VSTATE_OVER;
		queue_snap(s);
		s = nominal_snap();
		s.volt_low_limit = 1'b1;
		queue_snap(s);
		s = nominal_snap();
		s.batt_volt_state = VSTATE_UNDER;
		queue_snap(s);
		s.batt_volt_state = VSTATE_SPARE;
		queue_snap(s);
		s = nominal_snap();
		s.now_cap = '1;
		s.total_cap = '0;
		queue_snap(s);
		s = nominal_snap();
		s.sum_volt = '1;
		queue_snap(s);
		s.sum_volt = '0;
		queue_snap(s);
		s = nominal_snap();
		s.now_cap = 20'd1;
		s.total_cap = 20'd2;
		s.curr_dir = DIR_DISCHARGE;
		s.out_power = 16'sd1000;
		s.avg_current = 16'sd1000;
		queue_snap(s);
		s.chg_limit_curr = '0;
		s.dhg_limit_curr = '0;
		queue_snap(s);
		s = nominal_snap();
		s.curr_dir = DIR_CHARGE;
		s.out_power = -16'sd2;
		s.avg_current = -16'sd2;
		s.total_cap = '1;
		s.now_cap = '0;
		queue_snap(s);
		queue_snap(s);
		s.in_init = 1'b1;
		s.now_cap = '1;
		s.sum_volt = '0;
		queue_snap(s);
		s.in_init = 1'b0;
		s.total_cap = '1;
		s.sum_volt = '1;
		s.out_power = 16'sh7FFF;
		s.volt_high_limit = 1'b1;
		s.volt_low_limit = 1'b1;
		s.batt_volt_state = VSTATE_SPARE;
		s.curr_dir = DIR_SPARE;
		s.avg_current = 16'sh7FFF;
		s.chg_limit_curr = '1;
		s.dhg_limit_curr = '1;
		queue_snap(s);
		s.now_cap = '0;
		s.total_cap = '0;
		s.sum_volt = '0;
		s.out_power = 16'sd0;
		s.volt_high_limit = 1'b0;
		s.volt_low_limit = 1'b0;
		s.batt_volt_state = '0;
		s.curr_dir = '0;
		s.avg_current = 16'sd0;
		s.chg_limit_curr = '0;
		s.dhg_limit_curr = '0;
		queue_snap(s);

		chg_plan = '{16'd100, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF};
		dhg_plan = '{16'd100, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF};
		chg_plan[4] = WORD_W'($urandom);
		dhg_plan[4] = WORD_W'($urandom);

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk == 2) begin
				tx_idle_pct = 61;
				rx_idle_pct = 25;
			end else if (blk == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (blk != 0) begin
				wait_drained();
				write_reg(REG_CHG_RATED_POWER, chg_plan[blk]);
				write_reg(REG_DHG_RATED_POWER, dhg_plan[blk]);
			end
			for (int n = 0; n < BLOCK_ITEMS; n++)
				queue_snap(random_snap());
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_times.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
design/ttfe_pkg.sv
design/ttfe_if.sv
design/ttfe_div.sv
design/battery_time_to_full_empty_estimator.sv
bench/tb.sv
